// ===== rtl/core/lru_miss_counter_macros.svh =====
// ----------------------------------------------------------------------------
// lru_miss_counter_macros.svh
// Assertion macros for the LRU miss counter; empty bodies under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef LRU_MISS_COUNTER_MACROS_SVH
`define LRU_MISS_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define LMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_miss_counter: check failed");

// next-cycle implication, disabled during reset
`define LMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_miss_counter: check failed");

`else

`define LMC_ASSERT_NOW(lbl, ante, cons)
`define LMC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/lrumc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrumc_pkg
// Shared widths, defaults and register map of the LRU miss counter.
// ----------------------------------------------------------------------------
package lrumc_pkg;

	localparam int WAYS_DEF      = 16;
	localparam int PAGE_BITS_DEF = 16;

	localparam int PAGE_W = 16;
	localparam int MISS_W = 24;
	localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// APB register map
	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:2-ADDR_W+ADDR_W-2+0] REG_CAPACITY_WORD = '0;

endpackage

// ===== rtl/core/lru_miss_counter.sv =====
// ----------------------------------------------------------------------------
// lru_miss_counter
// Fully associative cache directory with LRU replacement that reports, for
// each page request, whether it hit and the saturating count of misses.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------
//  request   in         in_valid / in_ready  page
//  result    out        out_valid/out_ready  hit, miss_count
//  config    in         APB psel/penable     capacity at byte address 0
//
//  One request per cycle unless a result stalls: lookup and update cover all
//  ways at once. A request passes the request stage, then the result register.
//  Reset clears all valid bits, ranks and the miss count; capacity goes to 16.
//  A stalled result holds the request stage, which then holds in_ready low.
//
`include "lru_miss_counter_macros.svh"

module lru_miss_counter #(
	parameter int WAYS      = lrumc_pkg::WAYS_DEF,
	parameter int PAGE_BITS = lrumc_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lrumc_pkg::PAGE_W-1:0]  page,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [lrumc_pkg::MISS_W-1:0]  miss_count,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrumc_pkg::ADDR_W-1:0]  paddr,
	input  logic [lrumc_pkg::DATA_W-1:0]  pwdata,
	output logic [lrumc_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	import lrumc_pkg::*;

	localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OW = $clog2(WAYS + 1);
	localparam int EW = (CAP_W > OW) ? CAP_W : OW;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	logic [CAP_W-1:0] cap_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && (paddr[ADDR_W-1:2-ADDR_W+ADDR_W-2+0] == REG_CAPACITY_WORD)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = DATA_W'(cap_q);

	// ------------------------------------------------------------------
	// request stage
	// ------------------------------------------------------------------
	logic                 s1_valid_q;
	logic [PAGE_W-1:0]    page_s1;
	logic                 adv;

	// the request stage moves on when the result register is free
	assign adv      = !out_valid || out_ready;
	assign in_ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			page_s1 <= page;
		end
	end

	// ------------------------------------------------------------------
	// directory state
	// ------------------------------------------------------------------
	logic [PAGE_BITS-1:0] entry_page_q    [WAYS];
	logic [WAYS-1:0]      entry_valid_q;
	logic [RW-1:0]        entry_recency_q [WAYS];
	logic [MISS_W-1:0]    misses_q;

	// ------------------------------------------------------------------
	// lookup
	// ------------------------------------------------------------------
	logic [PAGE_BITS-1:0] key;
	logic [WAYS-1:0]      match;
	logic [WAYS-1:0]      free_1h;
	logic [WAYS-1:0]      oldest_1h;
	logic [WAYS-1:0]      slot_1h;
	logic [WAYS-1:0]      age_en;
	logic [OW-1:0]        occ;
	logic [RW-1:0]        found_rank;
	logic [RW-1:0]        oldest_rank;
	logic [EW-1:0]        cap_eff;
	logic                 hit_c;
	logic                 evict;
	logic                 do_upd;

	assign key         = PAGE_BITS'(page_s1);
	assign do_upd      = s1_valid_q && adv;
	assign oldest_rank = RW'(occ - OW'(1));

	always_comb begin
		occ        = '0;
		found_rank = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w]     = entry_valid_q[w] && (entry_page_q[w] == key);
			occ          = occ + OW'(entry_valid_q[w]);
			found_rank   = found_rank | (match[w] ? entry_recency_q[w] : '0);
		end
	end

	// ranks of valid ways are distinct 0..occ-1, so the oldest holds occ-1
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			oldest_1h[w] = entry_valid_q[w] && (entry_recency_q[w] == oldest_rank);
		end
	end

	// lowest free way
	assign free_1h = ~entry_valid_q & (~(~entry_valid_q) + WAYS'(1));

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = EW'(1);
		end else if (EW'(cap_q) > EW'(WAYS)) begin
			cap_eff = EW'(WAYS);
		end else begin
			cap_eff = EW'(cap_q);
		end
	end

	assign hit_c   = |match;
	assign evict   = (free_1h == '0) || (EW'(occ) >= cap_eff);
	assign slot_1h = evict ? oldest_1h : free_1h;

	// ways that age by one step
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (hit_c) begin
				age_en[w] = entry_valid_q[w] && (entry_recency_q[w] < found_rank);
			end else if (evict) begin
				age_en[w] = entry_valid_q[w] && (entry_recency_q[w] < oldest_rank);
			end else begin
				age_en[w] = entry_valid_q[w];
			end
		end
	end

	// ------------------------------------------------------------------
	// update
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			misses_q      <= '0;
			for (int w = 0; w < WAYS; w++) begin
				entry_recency_q[w] <= '0;
			end
		end else if (do_upd) begin
			for (int w = 0; w < WAYS; w++) begin
				if (hit_c ? match[w] : slot_1h[w]) begin
					entry_recency_q[w] <= '0;
				end else if (age_en[w]) begin
					entry_recency_q[w] <= entry_recency_q[w] + RW'(1);
				end
			end
			if (!hit_c) begin
				entry_valid_q <= entry_valid_q | slot_1h;
				if (misses_q != MISS_MAX) begin
					misses_q <= misses_q + MISS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd && !hit_c) begin
			for (int w = 0; w < WAYS; w++) begin
				if (slot_1h[w]) begin
					entry_page_q[w] <= key;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd) begin
			hit        <= hit_c;
			miss_count <= (hit_c || (misses_q == MISS_MAX)) ? misses_q
			                                                : misses_q + MISS_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`LMC_ASSERT_NEXT(a_hit_keeps_count, do_upd && hit_c, $stable(misses_q))
	`LMC_ASSERT_NEXT(a_count_monotonic, 1'b1, misses_q >= $past(misses_q))
	`LMC_ASSERT_NEXT(a_valid_never_drops, 1'b1,
		$countones(entry_valid_q) >= $past($countones(entry_valid_q)))
	`LMC_ASSERT_NOW(a_miss_has_slot, do_upd && !hit_c, $onehot(slot_1h))
	`LMC_ASSERT_NEXT(a_stalled_holds, s1_valid_q && !adv, s1_valid_q && $stable(page_s1))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU miss counter: page requests go in through a
// queue-fed driver, a monitor mirrors the cache directory and miss counter to
// predict hit flag and miss count, and compares each result in order, over a
// range of capacities and flow-control mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import lrumc_pkg::*;

	localparam int WAYS = WAYS_DEF;
	localparam int HOT_N = 24;
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = '0;

	typedef struct packed {
		logic              hit;
		logic [MISS_W-1:0] miss_count;
	} lookup_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [PAGE_W-1:0]   page = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                hit;
	logic [MISS_W-1:0]   miss_count;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// mirror of the cache directory
	logic [PAGE_W-1:0]   way_page [WAYS];
	logic                way_valid [WAYS];
	logic [3:0]          way_rank [WAYS];
	logic [MISS_W-1:0]   miss_total = '0;
	logic [CAP_W-1:0]    cap_cfg = CAP_RESET;

	logic [PAGE_W-1:0]   request_pages [$];
	lookup_t             pending_lookups [$];
	logic [PAGE_W-1:0]   hot_pages [HOT_N];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int requests = 0;
	int hits_seen = 0;
	int results_seen = 0;
	int settings = 1;

	lru_miss_counter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.page       (page),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.miss_count (miss_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		for (int w = 0; w < WAYS; w++) begin
			way_page[w] = '0;
			way_valid[w] = 1'b0;
			way_rank[w] = '0;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// advance every valid way younger than limit by one rank
	function automatic void age_ranks(input int limit);
		for (int w = 0; w < WAYS; w++)
			if (way_valid[w] && way_rank[w] < limit)
				way_rank[w] = way_rank[w] + 4'd1;
	endfunction

	task automatic lru_access(input logic [PAGE_W-1:0] pg, output lookup_t res);
		int found, free_way, oldest, oldest_rank, occ, eff, slot;
		found = -1;
		free_way = -1;
		oldest = -1;
		oldest_rank = 0;
		occ = 0;
		eff = (cap_cfg < 1) ? 1 : (cap_cfg > WAYS) ? WAYS : int'(cap_cfg);
		for (int w = 0; w < WAYS; w++) begin
			if (way_valid[w]) begin
				occ++;
				if (found < 0 && way_page[w] == pg)
					found = w;
				if (oldest < 0 || way_rank[w] >= oldest_rank) begin
					oldest = w;
					oldest_rank = way_rank[w];
				end
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		if (found >= 0) begin
			age_ranks(way_rank[found]);
			way_rank[found] = '0;
			res.hit = 1'b1;
		end else begin
			if (miss_total != MISS_MAX)
				miss_total = miss_total + 1'b1;
			// a full directory (or one over a lowered capacity) replaces the oldest page
			if (occ >= eff || free_way < 0) begin
				slot = oldest;
				age_ranks(oldest_rank);
			end else begin
				slot = free_way;
				age_ranks(WAYS + 1);
			end
			way_page[slot] = pg;
			way_valid[slot] = 1'b1;
			way_rank[slot] = '0;
			res.hit = 1'b0;
		end
		res.miss_count = miss_total;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (request_pages.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				page <= request_pages.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// predict on request transfer, check on result transfer
	always @(posedge clk) begin
		lookup_t predicted;
		lookup_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				lru_access(page, predicted);
				pending_lookups.push_back(predicted);
				requests++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (hit)
					hits_seen++;
				if (pending_lookups.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = pending_lookups.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("result %0d: hit %0b, want %0b",
							results_seen, hit, want.hit));
					if (miss_count !== want.miss_count)
						report_mismatch($sformatf("result %0d: miss_count %0d, want %0d",
							results_seen, miss_count, want.miss_count));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// hold until every queued request is through and its result is back
	task automatic drain();
		while (request_pages.size() != 0 || in_valid || pending_lookups.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cap_write(input logic [CAP_W-1:0] val);
		logic [DATA_W-1:0] wdata;
		wdata = DATA_W'($urandom);
		wdata[CAP_W-1:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cap_cfg = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic cap_read_check();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAPACITY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CAP_W-1:0] !== cap_cfg)
			report_mismatch($sformatf("capacity read %0d, want %0d",
				prdata[CAP_W-1:0], cap_cfg));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int sidle,
			input int rstall, input int n);
		int eff, r, idx;
		logic [PAGE_W-1:0] pg;
		drain();
		cap_write(cap);
		cap_read_check();
		settings++;
		for (int k = 0; k < HOT_N; k++)
			hot_pages[k] = PAGE_W'($urandom);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		eff = (cap < 1) ? 1 : (cap > WAYS) ? WAYS : int'(cap);
		repeat (n) begin
			r = $urandom_range(99);
			idx = $urandom_range((eff + 4 < HOT_N) ? eff + 4 : HOT_N - 1);
			if (r < 78)
				pg = hot_pages[idx];
			else if (r < 90)
				pg = hot_pages[idx] ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1));
			else
				pg = PAGE_W'($urandom);
			request_pages.push_back(pg);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		cap_read_check();

		// field extremes, hits and misses at the reset capacity
		request_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h5555, 16'hAAAA, 16'h5555};
		drain();

		// capacity zero acts as one; the lowered capacity keeps the pages it holds
		cap_write('0);
		request_pages = '{16'h1234, 16'h1234, 16'h0000, 16'hAAAA, 16'h1234};
		drain();

		// capacity above the way count saturates; fill past sixteen to force eviction
		cap_write('1);
		for (int k = 0; k < 13; k++)
			request_pages.push_back(16'h8000 + PAGE_W'(k));
		request_pages.push_back(16'h8000);

		run_phase(5'd16, 0, 0, 160);
		run_phase(5'd1, 71, 0, 120);
		run_phase(5'd4, 0, 71, 150);
		run_phase(5'd16, 18, 18, 150);
		run_phase(5'd2, 71, 0, 120);
		run_phase(5'd8, 0, 71, 150);
		run_phase(5'd31, 18, 18, 150);
		run_phase(5'd0, 0, 0, 100);
		run_phase(5'd12, 71, 71, 100);
		drain();

		$display("Covered %0d requests (%0d hits) across %0d capacity settings,",
			requests, hits_seen, settings + 2);
		$display("with sender gaps and receiver stalls mixed in by phase.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4800000;
		$display("FAILURE");
		$finish;
	end

endmodule
